### rtl/core/qrdmp_pkg.sv
// Shared types, result codes and small arithmetic helpers for QR data module placement.
`timescale 1ns / 1ps
package qrdmp_pkg;

  localparam int AlignMax = 7;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_PAST    = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]                n;
    logic [2:0]                cnt;
    logic [AlignMax-1:0][7:0]  al;
    logic                      v7;
  } geom_t;

  function automatic logic [6:0] div3(input logic [7:0] v);
    logic [16:0] p;
    p = 17'(v) * 17'd171;
    return p[15:9];
  endfunction

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [8:0] t;
    t = 9'(v) - 9'(div3(v)) * 9'd3;
    return t[1:0];
  endfunction

  function automatic logic [1:0] mod3_small(input logic [3:0] v);
    logic [1:0] r;
    case (v)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      4'd2, 4'd5, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/qrdmp_classify.sv
// Function-area classification and data mask evaluation of one module position.
`timescale 1ns / 1ps
module qrdmp_classify (
  input  logic [7:0]           x,
  input  logic [7:0]           y,
  input  qrdmp_pkg::geom_t     geom,
  input  logic [2:0]           mask,
  output qrdmp_pkg::status_t   status,
  output logic                 invert
);
  import qrdmp_pkg::*;

  logic [2:0] xi;
  logic [2:0] yi;
  logic       on_align;
  logic       on_func;
  logic [8:0] n9;
  logic [1:0] xm3;
  logic [1:0] ym3;
  logic [1:0] pm3;
  logic [1:0] sm3;
  logic       p2;
  logic [8:0] sum;
  logic [6:0] h4;
  logic       mbit;

  always_comb begin
    xi = '0;
    yi = '0;
    for (int k = 0; k < AlignMax; k++) begin
      if (3'(k) < geom.cnt) begin
        if (9'(x) + 9'd2 >= 9'(geom.al[k]) && 9'(x) <= 9'(geom.al[k]) + 9'd2) xi = 3'(k + 1);
        if (9'(y) + 9'd2 >= 9'(geom.al[k]) && 9'(y) <= 9'(geom.al[k]) + 9'd2) yi = 3'(k + 1);
      end
    end
    on_align = (xi != 3'd0) && (yi != 3'd0)
               && !(xi == 3'd1 && yi == 3'd1)
               && !(xi == geom.cnt && yi == 3'd1)
               && !(xi == 3'd1 && yi == geom.cnt);

    n9 = 9'(geom.n);
    on_func = 1'b0;
    if (x < 8'd8 && y < 8'd8) on_func = 1'b1;
    if (x < 8'd8 && 9'(y) + 9'd8 >= n9) on_func = 1'b1;
    if (9'(x) + 9'd8 >= n9 && y < 8'd8) on_func = 1'b1;
    if (on_align) on_func = 1'b1;
    if (x == 8'd6 || y == 8'd6) on_func = 1'b1;
    if (y == 8'd8 && (x <= 8'd8 || 9'(x) + 9'd8 >= n9)) on_func = 1'b1;
    if (x == 8'd8 && (y <= 8'd8 || 9'(y) + 9'd8 >= n9)) on_func = 1'b1;
    if (geom.v7) begin
      if (x < 8'd7 && 9'(y) + 9'd11 >= n9 && 9'(y) + 9'd9 <= n9) on_func = 1'b1;
      if (y < 8'd7 && 9'(x) + 9'd11 >= n9 && 9'(x) + 9'd9 <= n9) on_func = 1'b1;
    end

    xm3 = mod3(x);
    ym3 = mod3(y);
    pm3 = mod3_small(4'(xm3) * 4'(ym3));
    sm3 = mod3_small(4'(xm3) + 4'(ym3));
    p2  = x[0] & y[0];
    sum = 9'(x) + 9'(y);
    h4  = 7'(y[7:1]) + div3(x);
    case (mask)
      3'd0:    mbit = !sum[0];
      3'd1:    mbit = !y[0];
      3'd2:    mbit = (xm3 == 2'd0);
      3'd3:    mbit = (sm3 == 2'd0);
      3'd4:    mbit = !h4[0];
      3'd5:    mbit = !p2 && (pm3 == 2'd0);
      3'd6:    mbit = !(p2 ^ pm3[0]);
      default: mbit = !(pm3[0] ^ sum[0]);
    endcase

    status = on_func ? ST_SKIPPED : ST_DATA;
    invert = on_func ? 1'b0 : mbit;
  end

endmodule

### rtl/core/qr_data_module_placement_unit.sv
// Top level of the QR data module placement pipeline.
// One item per cycle while the output is not stalled; each item passes an
// input register and then four more register stages: a reciprocal multiply
// for the strip number, a remainder stage, a correction stage that forms
// column and row, and the output register that follows classification.
// Per-version geometry is read from constant tables into a geometry register
// that follows the version register.
`timescale 1ns / 1ps
module qr_data_module_placement_unit #(
  parameter int MAX_VERSION = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [14:0] bit_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] status, [9:2] column, [17:10] row, [18] invert
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import qrdmp_pkg::*;

  localparam logic [1:0] RegVersion = 2'd0;
  localparam logic [1:0] RegMask    = 2'd1;

  logic [5:0]  version_number;
  logic [2:0]  mask_pattern;
  logic [5:0]  veff;

  logic [18:0] recip_tab [1:MAX_VERSION];
  logic [14:0] thr_tab   [1:MAX_VERSION];
  logic [2:0]  cnt_tab   [1:MAX_VERSION];
  logic [7:0]  al_tab    [1:MAX_VERSION][0:AlignMax-1];

  for (genvar g = 1; g <= MAX_VERSION; g++) begin : g_ver
    localparam int N    = 17 + 4 * g;
    localparam int CNT  = (g > 1) ? g / 7 + 2 : 0;
    localparam int STEP = (g > 1) ? ((((g + 1) * 8 / (CNT - 1)) + 3) / 4) * 2 : 0;
    assign recip_tab[g] = 19'((1 << 24) / (2 * N));
    assign thr_tab[g]   = 15'((N - 7) * N);
    assign cnt_tab[g]   = 3'(CNT);
    for (genvar k = 0; k < AlignMax; k++) begin : g_al
      localparam int R = STEP * (CNT - k - 1);
      localparam int C = (k >= CNT) ? 0 : ((4 * g < R) ? 6 : 4 * g - R + 10);
      assign al_tab[g][k] = 8'(C);
    end
  end

  geom_t       geom;
  logic [18:0] recip;
  logic [14:0] thr;
  logic [8:0]  d2n;

  always_comb begin
    veff = version_number;
    if (veff == 6'd0) veff = 6'd1;
    if (veff > 6'(MAX_VERSION)) veff = 6'(MAX_VERSION);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_number <= 6'd1;
      mask_pattern   <= 3'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == RegVersion) version_number <= cfg_data;
      if (cfg_index == RegMask) mask_pattern <= cfg_data[2:0];
    end
  end

  always_ff @(posedge clk) begin
    geom.n   <= 8'(17 + 4 * 32'(veff));
    geom.cnt <= cnt_tab[veff];
    geom.v7  <= (veff >= 6'd7);
    for (int k = 0; k < AlignMax; k++) geom.al[k] <= al_tab[veff][k];
    recip    <= recip_tab[veff];
    thr      <= thr_tab[veff];
  end

  assign d2n = {geom.n, 1'b0};

  // Stage A: input register.
  logic        va, vb, vc, vd;
  logic        ra, rb, rc, rd;
  logic        o_ready;
  logic [14:0] a_i;

  // Stage B: reciprocal product.
  logic [33:0] b_prod;
  logic [14:0] b_i;

  // Stage C: strip estimate and remainder.
  logic [9:0]  c_q;
  logic [9:0]  c_rem;
  logic        c_b0;
  logic        c_t;

  // Stage D: coordinates.
  logic signed [11:0] d_x;
  logic [7:0]         d_y;

  logic [23:0] out_data;

  assign o_ready = !m_tvalid || m_tready;
  assign rd = !vd || o_ready;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign s_tready = ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (ra) va <= s_tvalid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
    end
  end

  logic [9:0]  q_est;
  logic [18:0] qd;
  logic [14:0] rem_full;
  logic [9:0]  q_fix;
  logic [9:0]  r_fix;
  logic signed [11:0] x_calc;
  logic [7:0]  y_calc;

  always_comb begin
    q_est    = b_prod[33:24];
    qd       = 19'(q_est) * 19'(d2n);
    rem_full = b_i - qd[14:0];
    if (c_rem >= 10'(d2n)) begin
      q_fix = c_q + 10'd1;
      r_fix = c_rem - 10'(d2n);
    end else begin
      q_fix = c_q;
      r_fix = c_rem;
    end
    x_calc = 12'(geom.n) - 12'sd1 - 12'(c_b0) - 12'({q_fix, 1'b0}) - 12'(c_t);
    if (q_fix[0]) y_calc = r_fix[8:1];
    else y_calc = geom.n - 8'd1 - r_fix[8:1];
  end

  always_ff @(posedge clk) begin
    if (ra && s_tvalid) a_i <= s_tdata[14:0];
    if (rb && va) begin
      b_prod <= 34'(a_i) * 34'(recip);
      b_i    <= a_i;
    end
    if (rc && vb) begin
      c_q   <= q_est;
      c_rem <= rem_full[9:0];
      c_b0  <= b_i[0];
      c_t   <= (b_i >= thr);
    end
    if (rd && vc) begin
      d_x <= x_calc;
      d_y <= y_calc;
    end
  end

  status_t cls_status;
  logic    cls_invert;

  qrdmp_classify u_classify (
    .x      (d_x[7:0]),
    .y      (d_y),
    .geom   (geom),
    .mask   (mask_pattern),
    .status (cls_status),
    .invert (cls_invert)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_ready) begin
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && vd) begin
      if (d_x < 0) out_data <= {5'd0, 1'b0, 8'd0, 8'd0, ST_PAST};
      else out_data <= {5'd0, cls_invert, d_y, d_x[7:0], cls_status};
    end
  end

  assign m_tdata = out_data;

endmodule

### rtl/core/qrdmp_checker.sv
// Port-level checker for the QR data module placement unit, with its bind.
`timescale 1ns / 1ps
module qrdmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import qrdmp_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_DATA || m_tdata[1:0] == ST_SKIPPED
                  || m_tdata[1:0] == ST_PAST))
    else $error("Result item carries an unknown status code.");

  a_past_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_PAST) |-> (m_tdata[18:2] == 17'd0))
    else $error("Past-end item has nonzero coordinates or invert.");

  a_skip_noinv: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_SKIPPED) |-> !m_tdata[18])
    else $error("Skipped module reports an inverted mask bit.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("Stalled result item changed or vanished.");

endmodule

bind qr_data_module_placement_unit qrdmp_checker u_qrdmp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### verif/qr_data_module_placement_unit_tb.sv
// Self-checking testbench for the QR data module placement unit.
`timescale 1ns / 1ps
module qr_data_module_placement_unit_tb;
  import qrdmp_pkg::*;

  localparam int MaxVer = 40;
  localparam logic [1:0] RegVersion = 2'd0;
  localparam logic [1:0] RegMask = 2'd1;
  localparam logic [1:0] RegUnused = 2'd2;

  typedef struct {
    status_t    status;
    logic [7:0] column;
    logic [7:0] row;
    logic       invert;
  } module_pos_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  logic [5:0]  cur_version;
  logic [2:0]  cur_mask;
  module_pos_t placement_q[$];
  int          mismatches;
  int          stall_mode;

  qr_data_module_placement_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int align_center(int ver, int idx);
    int cnt, stp, r;
    cnt = ver / 7 + 2;
    stp = ((((ver + 1) * 8 / (cnt - 1)) + 3) / 4) * 2;
    r = stp * (cnt - idx - 1);
    return (4 * ver < r) ? 6 : 4 * ver - r + 10;
  endfunction

  function automatic bit is_function_module(int ver, int n, int x, int y);
    int cnt, xi, yi, c;
    cnt = (ver > 1) ? ver / 7 + 2 : 0;
    xi = 0;
    yi = 0;
    if (x < 8 && y < 8) return 1;
    if (x < 8 && y >= n - 8) return 1;
    if (x >= n - 8 && y < 8) return 1;
    for (int k = 0; k < cnt; k++) begin
      c = align_center(ver, k);
      if (c - 2 <= x && x <= c + 2) xi = k + 1;
      if (c - 2 <= y && y <= c + 2) yi = k + 1;
    end
    if (xi != 0 && yi != 0 && !(xi == 1 && yi == 1) && !(xi == cnt && yi == 1)
        && !(xi == 1 && yi == cnt)) return 1;
    if (x == 6 || y == 6) return 1;
    if (y == 8 && (x <= 8 || x >= n - 8)) return 1;
    if (x == 8 && (y <= 8 || y >= n - 8)) return 1;
    if (ver >= 7) begin
      if (x < 7 && n - 11 <= y && y <= n - 9) return 1;
      if (y < 7 && n - 11 <= x && x <= n - 9) return 1;
    end
    return 0;
  endfunction

  function automatic bit mask_inverts(int x, int y, int m);
    int p, s;
    p = x * y;
    s = x + y;
    case (m)
      0: return s % 2 == 0;
      1: return y % 2 == 0;
      2: return x % 3 == 0;
      3: return s % 3 == 0;
      4: return (y / 2 + x / 3) % 2 == 0;
      5: return (p % 2) + (p % 3) == 0;
      6: return ((p % 2) + (p % 3)) % 2 == 0;
      default: return ((p % 3) + (s % 2)) % 2 == 0;
    endcase
  endfunction

  function automatic module_pos_t place_bit(logic [14:0] bit_index);
    module_pos_t res;
    int ver, n, i, sub, x, y;
    ver = cur_version;
    if (ver < 1) ver = 1;
    if (ver > MaxVer) ver = MaxVer;
    n = 17 + 4 * ver;
    i = bit_index;
    sub = (i / 2) % (2 * n);
    x = n - 1 - (i % 2) - 2 * (i / (2 * n)) - ((i >= (n - 7) * n) ? 1 : 0);
    if (i % (4 * n) < 2 * n) y = n - 1 - sub;
    else y = sub - n;
    res = '{ST_PAST, 8'd0, 8'd0, 1'b0};
    if (x < 0 || y < 0) return res;
    res.column = x[7:0];
    res.row = y[7:0];
    if (is_function_module(ver, n, x, y)) res.status = ST_SKIPPED;
    else begin
      res.status = ST_DATA;
      res.invert = mask_inverts(x, y, cur_mask);
    end
    return res;
  endfunction

  task automatic send_bit(input logic [14:0] bit_index);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, bit_index};
    placement_q.push_back(place_bit(bit_index));
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == RegVersion) cur_version = value;
    else if (idx == RegMask) cur_mask = value[2:0];
    @(posedge clk);
  endtask

  task automatic test_directed;
    send_bit(15'd0);
    send_bit(15'd1);
    send_bit(15'd2);
    send_bit(15'd41);
    send_bit(15'd42);
    send_bit(15'd84);
    send_bit(15'd100);
    send_bit(15'd200);
    send_bit(15'd255);
    send_bit(15'd299);
    send_bit(15'd300);
    send_bit(15'd441);
    send_bit(15'd442);
    send_bit(15'h5555);
    send_bit(15'h2AAA);
    send_bit(15'h7FFF);
    drain();
  endtask

  task automatic test_edges;
    write_reg(RegVersion, 6'd40);
    write_reg(RegMask, 6'd7);
    for (int k = 0; k < 10; k++) send_bit(15'(k * 3121));
    send_bit(15'h7FFF);
    drain();
    write_reg(RegVersion, 6'd0);
    write_reg(RegUnused, 6'h3F);
    for (int k = 0; k < 6; k++) send_bit(15'(k * 83));
    drain();
    write_reg(RegVersion, 6'h3F);
    send_bit(15'd31000);
    send_bit(15'd5);
    drain();
  endtask

  task automatic test_random;
    int total, span, n;
    total = 0;
    while (total < 900) begin
      write_reg(RegVersion, 6'($urandom_range(0, 63)));
      write_reg(RegMask, 6'($urandom_range(0, 7)));
      n = 17 + 4 * ((cur_version < 1) ? 1 : (cur_version > MaxVer) ? MaxVer : cur_version);
      span = n * n + 4 * n;
      if (span > 32767) span = 32767;
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 9) == 0) send_bit(15'($urandom));
        else send_bit(15'($urandom_range(0, span)));
      end
      total += 75;
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_version = 6'd1;
    cur_mask = 3'd0;
    mismatches = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_edges();
    test_random();
    if (mismatches == 0) $display("qr_data_module_placement_unit_tb: PASS");
    else $display("qr_data_module_placement_unit_tb: FAIL");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    module_pos_t exp_pos;
    if (!rst && m_tvalid && m_tready) begin
      if (placement_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", m_tdata);
      end else begin
        exp_pos = placement_q.pop_front();
        if (m_tdata[1:0] !== exp_pos.status || m_tdata[9:2] !== exp_pos.column ||
            m_tdata[17:10] !== exp_pos.row || m_tdata[18] !== exp_pos.invert) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d col=%0d row=%0d inv=%0d",
                     exp_pos.status, exp_pos.column, exp_pos.row, exp_pos.invert);
            $display("          got st=%0d col=%0d row=%0d inv=%0d",
                     m_tdata[1:0], m_tdata[9:2], m_tdata[17:10], m_tdata[18]);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("qr_data_module_placement_unit_tb: FAIL");
    $finish;
  end

endmodule
